/* design/pspr_pkg.sv */
// Shared types and constants of the perspective sprite projector.
package pspr_pkg;

    // Field widths of the request and response
    localparam int OP_W     = 2;
    localparam int PLANE_W  = 5;
    localparam int POS_W    = 8;
    localparam int DEPTH_W  = 10;
    localparam int SIZE_W   = 6;
    localparam int SEL_W    = 3;
    localparam int ENTRY_W  = 4;
    localparam int PAT_W    = 8;
    localparam int COLOR_W  = 4;
    localparam int SCREEN_W = 13;

    // Pattern store geometry and effective table select width (up to 32 tables)
    localparam int PAT_ENTRIES = 16;
    localparam int SEL_EXT_W   = 5;

    // Projection constants
    localparam int NEAR_Z       = 16;
    localparam int DEPTH_CLAMP  = 256;
    localparam int TABLE_SHIFT  = 8;
    localparam int DIRECT_SHIFT = 7;
    localparam int TABLE_MAX    = 255;
    localparam int INDEX_MAX    = 15;
    localparam int X_ORIGIN     = 128 - 16;
    localparam int Y_ORIGIN     = 95 - 16;
    localparam int SCREEN_MIN   = -4096;
    localparam int SCREEN_MAX   = 4095;

    typedef enum logic [OP_W-1:0] {
        OP_PROJ_TABLE  = 2'd0,
        OP_PROJ_DIRECT = 2'd1,
        OP_LOAD        = 2'd2,
        OP_NOP         = 2'd3
    } pspr_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HALVE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_READ,
        ST_DONE
    } pspr_state_t;

    typedef enum logic [1:0] {
        PH_Y,
        PH_X,
        PH_SIZE
    } pspr_phase_t;

endpackage

/* design/pspr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pspr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/pspr_div.sv */
// Shared restoring divider: one quotient bit per cycle.
module pspr_div #(
    parameter int DIV_W = 15,
    parameter int DVS_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             fits;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    // Next state of the iteration
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/perspective_sprite_projector.sv */
// Top level of the perspective sprite projector: sequencer, shared divider, pattern RAM.
//
// Takes one request at a time. Load and no-op requests finish in the cycle they are
// accepted. A projection is accepted, then halves position, depth and size
// until depth-16 fits the table (at most 4 times for a 10-bit depth and the default
// table size), then makes one pass through the shared restoring divider per quotient:
// y, x and, in pattern-table mode, the size index. Pattern-table mode adds a
// pattern RAM read, and a final state loads the response register. The
// perspective table is never stored; each entry min(255, i*256/(j+16)) is
// computed by the divider when needed. The response register frees the
// sequencer while an earlier result is still stalled, and a finished projection
// waits there only until the previous result is taken.
// Pattern entries read before they were loaded return undefined data.
module perspective_sprite_projector #(
    parameter int TABLE_DIM      = 64,
    parameter int PATTERN_TABLES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [pspr_pkg::OP_W-1:0]           opcode,
    input  logic [pspr_pkg::PLANE_W-1:0]        plane,
    input  logic signed [pspr_pkg::POS_W-1:0]   pos_x,
    input  logic signed [pspr_pkg::POS_W-1:0]   pos_y,
    input  logic [pspr_pkg::DEPTH_W-1:0]        depth_z,
    input  logic [pspr_pkg::SIZE_W-1:0]         object_size,
    input  logic [pspr_pkg::SEL_W-1:0]          table_select,
    input  logic [pspr_pkg::ENTRY_W-1:0]        entry_index,
    input  logic [pspr_pkg::PAT_W-1:0]          pattern_value,
    input  logic [pspr_pkg::COLOR_W-1:0]        sprite_color,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [pspr_pkg::PLANE_W-1:0]        out_plane,
    output logic signed [pspr_pkg::SCREEN_W-1:0] screen_x,
    output logic signed [pspr_pkg::SCREEN_W-1:0] screen_y,
    output logic [pspr_pkg::PAT_W-1:0]          out_pattern,
    output logic [pspr_pkg::COLOR_W-1:0]        out_color
);

    import pspr_pkg::*;

    localparam int TD_W = $clog2(TABLE_DIM);
    localparam int DIV_W = (TD_W + TABLE_SHIFT > POS_W + DIRECT_SHIFT) ?
                           TD_W + TABLE_SHIFT : POS_W + DIRECT_SHIFT;
    localparam int DVS_W = $clog2(TABLE_DIM + NEAR_Z);
    localparam int SUM_W = DIV_W + 2;
    localparam int RAM_DEPTH = PATTERN_TABLES * PAT_ENTRIES;
    localparam int RAM_AW = $clog2(RAM_DEPTH);

    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(SCREEN_MIN);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(SCREEN_MAX);

    // Control registers
    pspr_state_t state_reg, state_next;
    pspr_phase_t phase_reg, phase_next;
    logic        valid_reg, valid_next;

    // Working registers
    logic                       direct_reg, direct_next;
    logic [SEL_EXT_W-1:0]       sel_reg, sel_next;
    logic [PAT_W-1:0]           pattern_reg, pattern_next;
    logic [PLANE_W-1:0]         plane_reg, plane_next;
    logic [COLOR_W-1:0]         color_reg, color_next;
    logic signed [POS_W-1:0]    x_reg, x_next;
    logic signed [POS_W-1:0]    y_reg, y_next;
    logic [DEPTH_W-1:0]         z_reg, z_next;
    logic [SIZE_W-1:0]          size_reg, size_next;
    logic [TD_W-1:0]            col_reg, col_next;
    logic                       tbl_reg, tbl_next;
    logic                       neg_reg, neg_next;
    logic [ENTRY_W-1:0]         idx_reg, idx_next;
    logic signed [SCREEN_W-1:0] sx_reg, sx_next;
    logic signed [SCREEN_W-1:0] sy_reg, sy_next;

    // Response registers
    logic [PLANE_W-1:0]         oplane_reg, oplane_next;
    logic signed [SCREEN_W-1:0] ox_reg, ox_next;
    logic signed [SCREEN_W-1:0] oy_reg, oy_next;
    logic [PAT_W-1:0]           opat_reg, opat_next;
    logic [COLOR_W-1:0]         ocolor_reg, ocolor_next;

    // Divider and RAM hookup
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic             ram_wr_en;
    logic [RAM_AW-1:0] ram_wr_addr;
    logic             ram_rd_en;
    logic [RAM_AW-1:0] ram_rd_addr;
    logic [PAT_W-1:0] ram_rd_data;

    // Operand and result helpers
    logic                    accept;
    logic [SEL_EXT_W-1:0]    sel_in;
    logic signed [POS_W-1:0] v_sel;
    logic                    v_neg;
    logic [POS_W-1:0]        v_mag;
    logic                    v_in_table;
    logic [TD_W-1:0]         row;
    logic [DVS_W-1:0]        tbl_divisor;
    logic [DVS_W-1:0]        direct_divisor;
    logic [DIV_W-1:0]        q_clamped;
    logic signed [SUM_W-1:0] q_signed;
    logic signed [SUM_W-1:0] origin;
    logic signed [SUM_W-1:0] sum;
    logic signed [SCREEN_W-1:0] scr;

    pspr_div #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    pspr_ram #(
        .WIDTH (PAT_W),
        .DEPTH (RAM_DEPTH)
    ) u_pattern_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (pattern_value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign req_stall = (state_reg != ST_IDLE);

    // Pick the coordinate and the divisors for the current pass
    always_comb
    begin
        sel_in         = {{(SEL_EXT_W - SEL_W){1'b0}}, table_select};
        v_sel          = (phase_reg == PH_X) ? x_reg : y_reg;
        v_neg          = v_sel[POS_W-1];
        v_mag          = v_neg ? (~v_sel + 1'b1) : v_sel;
        v_in_table     = {1'b0, v_mag} < (POS_W + 1)'(TABLE_DIM);
        row            = ({2'b0, size_reg} > (SIZE_W + 2)'(TABLE_DIM - 1)) ?
                         TD_W'(TABLE_DIM - 1) : TD_W'(size_reg);
        tbl_divisor    = DVS_W'(col_reg) + DVS_W'(NEAR_Z);
        direct_divisor = (z_reg == '0) ? DVS_W'(1) : DVS_W'(z_reg);
    end

    // Turn the quotient into a saturated screen coordinate
    always_comb
    begin
        q_clamped = (tbl_reg && (div_quo > DIV_W'(TABLE_MAX))) ? DIV_W'(TABLE_MAX) : div_quo;
        q_signed  = neg_reg ? -signed'({2'b0, q_clamped}) : signed'({2'b0, q_clamped});
        origin    = (phase_reg == PH_X) ? SUM_W'(X_ORIGIN) : SUM_W'(Y_ORIGIN);
        sum       = q_signed + origin;
        if (sum < SAT_LO)
        begin
            scr = SCREEN_W'(SAT_LO);
        end
        else if (sum > SAT_HI)
        begin
            scr = SCREEN_W'(SAT_HI);
        end
        else
        begin
            scr = SCREEN_W'(sum);
        end
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        valid_next   = valid_reg && rsp_stall;
        direct_next  = direct_reg;
        sel_next     = sel_reg;
        pattern_next = pattern_reg;
        plane_next   = plane_reg;
        color_next   = color_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        size_next    = size_reg;
        col_next     = col_reg;
        tbl_next     = tbl_reg;
        neg_next     = neg_reg;
        idx_next     = idx_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        oplane_next  = oplane_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        opat_next    = opat_reg;
        ocolor_next  = ocolor_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = RAM_AW'({table_select, entry_index});
        ram_rd_en    = 1'b0;
        ram_rd_addr  = RAM_AW'({sel_reg, idx_reg});

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_LOAD:
                        begin
                            // Drop loads aimed past the last table
                            ram_wr_en = sel_in < SEL_EXT_W'(PATTERN_TABLES);
                        end
                        OP_PROJ_TABLE, OP_PROJ_DIRECT:
                        begin
                            direct_next  = (opcode == OP_PROJ_DIRECT);
                            sel_next     = (sel_in >= SEL_EXT_W'(PATTERN_TABLES)) ?
                                           SEL_EXT_W'(PATTERN_TABLES - 1) : sel_in;
                            pattern_next = pattern_value;
                            plane_next   = plane;
                            color_next   = sprite_color;
                            x_next       = pos_x;
                            y_next       = pos_y;
                            size_next    = object_size;
                            if ((opcode == OP_PROJ_TABLE) &&
                                (depth_z > DEPTH_W'(DEPTH_CLAMP)))
                            begin
                                z_next = DEPTH_W'(DEPTH_CLAMP);
                            end
                            else
                            begin
                                z_next = depth_z;
                            end
                            state_next = ST_HALVE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_HALVE:
            begin
                // Halve position, depth and size until the depth column fits
                if (z_reg > DEPTH_W'(TABLE_DIM + NEAR_Z - 1))
                begin
                    z_next    = z_reg >> 1;
                    x_next    = x_reg >>> 1;
                    y_next    = y_reg >>> 1;
                    size_next = size_reg >> 1;
                end
                else
                begin
                    col_next   = (z_reg > DEPTH_W'(NEAR_Z)) ?
                                 TD_W'(z_reg - DEPTH_W'(NEAR_Z)) : '0;
                    phase_next = PH_Y;
                    state_next = ST_DIV_START;
                end
            end

            ST_DIV_START:
            begin
                div_start = 1'b1;
                case (phase_reg)
                    PH_SIZE:
                    begin
                        div_dividend = DIV_W'(row) << TABLE_SHIFT;
                        div_divisor  = tbl_divisor;
                        tbl_next     = 1'b1;
                        neg_next     = 1'b0;
                    end
                    default:
                    begin
                        neg_next = v_neg;
                        tbl_next = v_in_table;
                        if (v_in_table)
                        begin
                            div_dividend = DIV_W'(v_mag) << TABLE_SHIFT;
                            div_divisor  = tbl_divisor;
                        end
                        else
                        begin
                            div_dividend = DIV_W'(v_mag) << DIRECT_SHIFT;
                            div_divisor  = direct_divisor;
                        end
                    end
                endcase
                state_next = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (phase_reg)
                        PH_Y:
                        begin
                            sy_next    = scr;
                            phase_next = PH_X;
                            state_next = ST_DIV_START;
                        end
                        PH_X:
                        begin
                            sx_next = scr;
                            if (direct_reg)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                phase_next = PH_SIZE;
                                state_next = ST_DIV_START;
                            end
                        end
                        default:
                        begin
                            idx_next   = (div_quo > DIV_W'(INDEX_MAX)) ?
                                         ENTRY_W'(INDEX_MAX) : ENTRY_W'(div_quo);
                            state_next = ST_READ;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // Hold until the response register is free
                if (!valid_reg || !rsp_stall)
                begin
                    valid_next  = 1'b1;
                    oplane_next = plane_reg;
                    ox_next     = sx_reg;
                    oy_next     = sy_reg;
                    opat_next   = direct_reg ? pattern_reg : ram_rd_data;
                    ocolor_next = color_reg;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_Y;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        direct_reg  <= direct_next;
        sel_reg     <= sel_next;
        pattern_reg <= pattern_next;
        plane_reg   <= plane_next;
        color_reg   <= color_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        size_reg    <= size_next;
        col_reg     <= col_next;
        tbl_reg     <= tbl_next;
        neg_reg     <= neg_next;
        idx_reg     <= idx_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        oplane_reg  <= oplane_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        opat_reg    <= opat_next;
        ocolor_reg  <= ocolor_next;
    end

    assign rsp_valid   = valid_reg;
    assign out_plane   = oplane_reg;
    assign screen_x    = ox_reg;
    assign screen_y    = oy_reg;
    assign out_pattern = opat_reg;
    assign out_color   = ocolor_reg;

endmodule

/* design/pspr_check.sv */
// Port-level checker for the perspective sprite projector, bound to the top level.
module pspr_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_stall,
    input  logic [pspr_pkg::OP_W-1:0]           opcode,
    input  logic                                rsp_valid,
    input  logic                                rsp_stall,
    input  logic [pspr_pkg::PLANE_W-1:0]        out_plane,
    input  logic signed [pspr_pkg::SCREEN_W-1:0] screen_x,
    input  logic signed [pspr_pkg::SCREEN_W-1:0] screen_y,
    input  logic [pspr_pkg::PAT_W-1:0]          out_pattern,
    input  logic [pspr_pkg::COLOR_W-1:0]        out_color
);

    import pspr_pkg::*;

    // Hold a stalled response and its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(out_plane) &&
        $stable(screen_x) && $stable(screen_y) && $stable(out_pattern) &&
        $stable(out_color))
        else $error("stalled response changed");

    // Finish a load or no-op request in the cycle it is taken
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (opcode == OP_LOAD || opcode == OP_NOP)
        |=> !req_stall)
        else $error("load request left the block busy");

    // Start the sequencer on a projection request
    a_proj_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall &&
        (opcode == OP_PROJ_TABLE || opcode == OP_PROJ_DIRECT)
        |=> req_stall)
        else $error("projection request did not start the sequencer");

    // Raise a response only at the end of a projection
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response without a projection in progress");

endmodule

bind perspective_sprite_projector pspr_check u_pspr_check (.*);
